FILE: src/pscm_pkg.sv
package pscm_pkg;

  localparam int FRAME_BITS_DEF = 24;
  localparam logic [15:0] TICKS_PER_MS_RST = 16'd1000;

  localparam logic [7:0] HDR_INDEX       = 8'h70;
  localparam logic [7:0] HDR_READ        = 8'h71;
  localparam logic [7:0] HDR_DATA        = 8'h72;
  localparam logic [7:0] DATA_ONLY_INDEX = 8'hFF;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_SLEEP = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_index;
    logic [15:0] value;
    logic        sdo;
  } in_word_t;

  typedef struct packed {
    logic        chip_select;
    logic        serial_clock;
    logic        serial_data;
    logic        busy_res;
    logic        accepted;
    logic [15:0] read_data;
    logic        read_valid;
  } res_word_t;

endpackage

FILE: src/pscm_in_reg.sv
module pscm_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pscm_pkg::in_word_t in_word,
  input  logic               load,
  output logic               word_valid,
  output pscm_pkg::in_word_t word
);
  import pscm_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     take;

  // The held word stays until the core passes it to the result register.
  assign in_stall   = valid_r && !load;
  assign take       = in_valid && !in_stall;
  assign valid_nxt  = take || (valid_r && !load);
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      word_r <= in_word;
    end
  end

endmodule

FILE: src/pscm_core.sv
module pscm_core #(
  parameter int FRAME_BITS = pscm_pkg::FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  pscm_pkg::in_word_t  cmd,
  input  logic                load,
  output pscm_pkg::res_word_t res
);
  import pscm_pkg::*;

  localparam int TW = $clog2(2 * FRAME_BITS + 3);
  localparam int JW = $clog2(FRAME_BITS);
  localparam logic [TW-1:0] LAST_TICK = TW'(2 * FRAME_BITS + 2);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_DATA = 2'd1,
    PEND_READ = 2'd2
  } pend_t;

  function automatic logic [FRAME_BITS-1:0] mk_word(input logic [7:0] hdr,
                                                    input logic [15:0] low);
    logic [31:0] full;
    full = {8'h00, hdr, low};
    return full[FRAME_BITS-1:0];
  endfunction

  mode_t                 mode_r, mode_a, mode_nxt;
  logic [TW-1:0]         tick_r, tick_a, tick_nxt;
  logic [FRAME_BITS-1:0] fword_r, fword_a, fword_nxt;
  pend_t                 pend_r, pend_a, pend_nxt;
  logic [15:0]           pdata_r, pdata_a, pdata_nxt;
  logic [15:0]           rshift_r, rshift_nxt;
  logic [31:0]           srem_r, srem_a, srem_nxt;
  logic                  sda_r, sda_nxt;
  logic [15:0]           tpm_r;
  logic [31:0]           sleep_len;
  logic                  sleep_start;
  logic [TW-1:0]         ph;
  logic [TW-2:0]         bitpos;
  logic [JW-1:0]         j;
  logic                  j_in_read;
  res_word_t             res_c;

  assign sleep_len = 32'(cmd.value) * 32'(tpm_r);
  assign ph        = tick_a - TW'(2);
  assign bitpos    = ph[TW-1:1];
  assign j         = JW'(FRAME_BITS - 1) - bitpos[JW-1:0];
  assign j_in_read = {1'b0, j} < (JW + 1)'(16);

  // Command acceptance, only while idle.
  always_comb begin
    mode_a      = mode_r;
    tick_a      = tick_r;
    fword_a     = fword_r;
    pend_a      = pend_r;
    pdata_a     = pdata_r;
    srem_a      = srem_r;
    sleep_start = 1'b0;
    if (mode_r == MODE_IDLE && cmd.req_type != REQ_NONE) begin
      case (req_t'(cmd.req_type))
        REQ_WRITE: begin
          mode_a = MODE_WRITE;
          tick_a = '0;
          if (cmd.reg_index == DATA_ONLY_INDEX) begin
            fword_a = mk_word(HDR_DATA, cmd.value);
            pend_a  = PEND_NONE;
          end else begin
            fword_a = mk_word(HDR_INDEX, {8'h00, cmd.reg_index});
            pend_a  = PEND_DATA;
            pdata_a = cmd.value;
          end
        end
        REQ_READ: begin
          mode_a  = MODE_WRITE;
          tick_a  = '0;
          fword_a = mk_word(HDR_INDEX, {8'h00, cmd.reg_index});
          pend_a  = PEND_READ;
        end
        REQ_SLEEP: begin
          // The accepting tick is already the first sleep tick.
          sleep_start = sleep_len != 32'd0;
          if (sleep_len > 32'd1) begin
            mode_a = MODE_SLEEP;
            srem_a = sleep_len - 32'd1;
          end
        end
        default: begin
          mode_a = mode_r;
        end
      endcase
    end
  end

  // Tick of the current frame or sleep.
  always_comb begin
    mode_nxt   = mode_a;
    tick_nxt   = tick_a;
    fword_nxt  = fword_a;
    pend_nxt   = pend_a;
    pdata_nxt  = pdata_a;
    rshift_nxt = rshift_r;
    srem_nxt   = srem_a;
    sda_nxt    = sda_r;
    res_c      = '0;
    res_c.chip_select  = 1'b1;
    res_c.serial_clock = 1'b1;
    res_c.accepted     = mode_r == MODE_IDLE && cmd.req_type != REQ_NONE;
    res_c.busy_res     = sleep_start;
    if (mode_a == MODE_WRITE || mode_a == MODE_READ) begin
      res_c.busy_res = 1'b1;
      if (tick_a == '0) begin
        sda_nxt = 1'b1;
        if (mode_a == MODE_READ) begin
          rshift_nxt = '0;
        end
      end else if (tick_a == TW'(1)) begin
        res_c.chip_select = 1'b0;
      end else if (tick_a < LAST_TICK) begin
        res_c.chip_select = 1'b0;
        if (!ph[0]) begin
          res_c.serial_clock = 1'b0;
          // Read bits hold SDA at its last level and sample SDO instead.
          if (mode_a == MODE_READ && j_in_read) begin
            if (cmd.sdo) begin
              rshift_nxt[j[3:0]] = 1'b1;
            end
          end else begin
            sda_nxt = fword_a[j];
          end
        end
      end
      if (tick_a >= LAST_TICK) begin
        if (mode_a == MODE_READ) begin
          res_c.read_valid = 1'b1;
          res_c.read_data  = rshift_r;
        end
        tick_nxt = '0;
        case (pend_a)
          PEND_DATA: begin
            mode_nxt  = MODE_WRITE;
            fword_nxt = mk_word(HDR_DATA, pdata_a);
          end
          PEND_READ: begin
            mode_nxt  = MODE_READ;
            fword_nxt = mk_word(HDR_READ, 16'h0000);
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
        pend_nxt = PEND_NONE;
      end else begin
        tick_nxt = tick_a + TW'(1);
      end
    end else if (mode_r == MODE_SLEEP) begin
      res_c.busy_res = 1'b1;
      if (srem_r <= 32'd1) begin
        srem_nxt = '0;
        mode_nxt = MODE_IDLE;
      end else begin
        srem_nxt = srem_r - 32'd1;
      end
    end
    // The SDA pin shows the level as driven during this tick.
    res_c.serial_data = sda_nxt;
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      tick_r   <= '0;
      fword_r  <= '0;
      pend_r   <= PEND_NONE;
      pdata_r  <= '0;
      rshift_r <= '0;
      srem_r   <= '0;
      sda_r    <= 1'b1;
      tpm_r    <= TICKS_PER_MS_RST;
    end else begin
      if (load) begin
        mode_r   <= mode_nxt;
        tick_r   <= tick_nxt;
        fword_r  <= fword_nxt;
        pend_r   <= pend_nxt;
        pdata_r  <= pdata_nxt;
        rshift_r <= rshift_nxt;
        srem_r   <= srem_nxt;
        sda_r    <= sda_nxt;
      end
      if (cfg_we) begin
        tpm_r <= cfg_data;
      end
    end
  end

endmodule

FILE: src/pscm_out_reg.sv
module pscm_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                word_valid,
  input  pscm_pkg::res_word_t res,
  output logic                load,
  output logic                out_valid,
  input  logic                out_stall,
  output pscm_pkg::res_word_t out_word
);
  import pscm_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  res_word_t word_r;

  assign load      = word_valid && (!valid_r || !out_stall);
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      word_r <= res;
    end
  end

endmodule

FILE: src/panel_spi_command_master_top.sv
// Three-wire SPI command master for a display panel. Every input word is one
// timing tick and yields exactly one result word with the pin levels of that
// tick, plus busy, accepted and read-back status. A command is taken only on
// a tick while the master is idle; a frame spans 2*FRAME_BITS+3 ticks and a
// sleep spans value*ticks_per_ms ticks. Words pass through an input register
// and a result register, and one word is taken per clock cycle while the
// result side keeps up.
module panel_spi_command_master_top #(
  parameter int FRAME_BITS = pscm_pkg::FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_reg_index,
  input  logic [15:0] in_value,
  input  logic        in_sdo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_chip_select,
  output logic        out_serial_clock,
  output logic        out_serial_data,
  output logic        out_busy_res,
  output logic        out_accepted,
  output logic [15:0] out_read_data,
  output logic        out_read_valid
);
  import pscm_pkg::*;

  in_word_t  in_word;
  in_word_t  cmd;
  logic      cmd_valid;
  logic      load;
  res_word_t res;
  res_word_t out_word;

  assign in_word.req_type  = in_req_type;
  assign in_word.reg_index = in_reg_index;
  assign in_word.value     = in_value;
  assign in_word.sdo       = in_sdo;

  pscm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .load       (load),
    .word_valid (cmd_valid),
    .word       (cmd)
  );

  pscm_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .load     (load),
    .res      (res)
  );

  pscm_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (cmd_valid),
    .res        (res),
    .load       (load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  assign out_chip_select  = out_word.chip_select;
  assign out_serial_clock = out_word.serial_clock;
  assign out_serial_data  = out_word.serial_data;
  assign out_busy_res     = out_word.busy_res;
  assign out_accepted     = out_word.accepted;
  assign out_read_data    = out_word.read_data;
  assign out_read_valid   = out_word.read_valid;

endmodule

FILE: src/pscm_checker.sv
module pscm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_chip_select,
  input logic        out_serial_clock,
  input logic        out_busy_res,
  input logic [15:0] out_read_data,
  input logic        out_read_valid
);

  // Read data is zero on every word that does not complete a read.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_data == 16'h0000)
    else $error("read_data nonzero without read_valid");

  // The serial clock only goes low inside an active chip select.
  a_clk_in_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_serial_clock |-> !out_chip_select && out_busy_res)
    else $error("serial clock low outside a frame");

  // An asserted chip select always belongs to a busy tick.
  a_cs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chip_select |-> out_busy_res)
    else $error("chip select low while not busy");

  // A read completes on the closing tick of its frame.
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_chip_select && out_serial_clock && out_busy_res)
    else $error("read completed away from the frame end");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_chip_select))
    else $error("stalled result word changed");

endmodule

bind panel_spi_command_master_top pscm_checker u_pscm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chip_select  (out_chip_select),
  .out_serial_clock (out_serial_clock),
  .out_busy_res     (out_busy_res),
  .out_read_data    (out_read_data),
  .out_read_valid   (out_read_valid)
);

FILE: tb/tb_panel_spi_command_master_top.sv
module tb_panel_spi_command_master_top;
  import pscm_pkg::*;

  localparam int FB = FRAME_BITS_DEF;
  localparam int FRAME_TICKS = 2 * FB + 3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {PM_IDLE, PM_SHIFT, PM_READ, PM_SLEEP} pm_mode_t;
  typedef enum logic [1:0] {NEXT_NONE, NEXT_DATA, NEXT_READ} next_frame_t;
  typedef enum int {SDO_LOW, SDO_HIGH, SDO_RAND} sdo_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_NONE;
  logic [7:0]  in_reg_index = '0;
  logic [15:0] in_value = '0;
  logic        in_sdo = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_chip_select;
  logic        out_serial_clock;
  logic        out_serial_data;
  logic        out_busy_res;
  logic        out_accepted;
  logic [15:0] out_read_data;
  logic        out_read_valid;

  panel_spi_command_master_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_reg_index     (in_reg_index),
    .in_value         (in_value),
    .in_sdo           (in_sdo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_serial_data  (out_serial_data),
    .out_busy_res     (out_busy_res),
    .out_accepted     (out_accepted),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid)
  );

  in_word_t  tick_q[$];
  res_word_t pin_expect[$];
  in_word_t  next_word;
  res_word_t want;

  int  err_count = 0;
  int  results_seen = 0;
  int  quiet = 0;
  int  send_wait = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  squeezed = 1'b0;
  bit  gaps_on = 1'b1;
  bit  word_taken = 1'b0;

  // Panel master state as predicted from the accepted words.
  pm_mode_t    pm_mode = PM_IDLE;
  next_frame_t pm_next = NEXT_NONE;
  int          pm_tick = 0;
  logic [FB-1:0] pm_frame = '0;
  logic [15:0] pm_data = '0;
  logic [15:0] pm_rdata = '0;
  logic [31:0] pm_left = '0;
  logic        pm_sda = 1'b1;
  logic [15:0] pm_tpm = TICKS_PER_MS_RST;

  // Stimulus planning: ticks the block will still be occupied, and its rate.
  logic [31:0] plan_busy = '0;
  logic [15:0] plan_tpm = TICKS_PER_MS_RST;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void load_frame(pm_mode_t m, logic [7:0] hdr, logic [15:0] low);
    logic [31:0] full;
    full = {8'h00, hdr, low};
    pm_mode = m;
    pm_tick = 0;
    pm_frame = full[FB-1:0];
  endfunction

  function automatic res_word_t panel_tick(in_word_t w);
    res_word_t r;
    logic [31:0] span;
    int j;
    int last_t;
    r = '0;
    r.chip_select = 1'b1;
    r.serial_clock = 1'b1;
    last_t = 2 * FB + 2;
    if (pm_mode == PM_IDLE && w.req_type != REQ_NONE) begin
      r.accepted = 1'b1;
      if (w.req_type == REQ_WRITE) begin
        if (w.reg_index == DATA_ONLY_INDEX) begin
          load_frame(PM_SHIFT, HDR_DATA, w.value);
          pm_next = NEXT_NONE;
        end else begin
          load_frame(PM_SHIFT, HDR_INDEX, {8'h00, w.reg_index});
          pm_next = NEXT_DATA;
          pm_data = w.value;
        end
      end else if (w.req_type == REQ_READ) begin
        load_frame(PM_SHIFT, HDR_INDEX, {8'h00, w.reg_index});
        pm_next = NEXT_READ;
      end else begin
        span = 32'(w.value) * 32'(pm_tpm);
        if (span != 0) begin
          pm_left = span;
          pm_mode = PM_SLEEP;
        end
      end
    end

    if (pm_mode == PM_SHIFT || pm_mode == PM_READ) begin
      r.busy_res = 1'b1;
      if (pm_tick == 0) begin
        pm_sda = 1'b1;
        if (pm_mode == PM_READ) pm_rdata = '0;
      end else if (pm_tick == 1) begin
        r.chip_select = 1'b0;
      end else if (pm_tick < last_t) begin
        j = FB - 1 - ((pm_tick - 2) >> 1);
        r.chip_select = 1'b0;
        if (((pm_tick - 2) & 1) == 0) begin
          r.serial_clock = 1'b0;
          // The low 16 bits of a read frame are sampled; SDA holds its level.
          if (pm_mode == PM_READ && j < 16) begin
            if (w.sdo) pm_rdata[j] = 1'b1;
          end else begin
            pm_sda = pm_frame[j];
          end
        end
      end
      if (pm_tick >= last_t) begin
        if (pm_mode == PM_READ) begin
          r.read_valid = 1'b1;
          r.read_data = pm_rdata;
        end
        case (pm_next)
          NEXT_DATA: load_frame(PM_SHIFT, HDR_DATA, pm_data);
          NEXT_READ: load_frame(PM_READ, HDR_READ, 16'h0000);
          default: begin
            pm_mode = PM_IDLE;
            pm_tick = 0;
          end
        endcase
        pm_next = NEXT_NONE;
      end else begin
        pm_tick++;
      end
    end else if (pm_mode == PM_SLEEP) begin
      r.busy_res = 1'b1;
      if (pm_left <= 1) begin
        pm_left = '0;
        pm_mode = PM_IDLE;
      end else begin
        pm_left--;
      end
    end
    r.serial_data = pm_sda;
    return r;
  endfunction

  function automatic void field_check(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic sdo_bit(sdo_mode_t m);
    if (m == SDO_LOW) return 1'b0;
    if (m == SDO_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  task automatic push_tick(logic [1:0] req, logic [7:0] idx, logic [15:0] val, logic sdo);
    in_word_t w;
    w.req_type = req;
    w.reg_index = idx;
    w.value = val;
    w.sdo = sdo;
    tick_q.push_back(w);
    if (plan_busy == 0 && req != REQ_NONE) begin
      case (req)
        REQ_WRITE: plan_busy = (idx == DATA_ONLY_INDEX) ? FRAME_TICKS : 2 * FRAME_TICKS;
        REQ_READ:  plan_busy = 2 * FRAME_TICKS;
        default:   plan_busy = 32'(val) * 32'(plan_tpm);
      endcase
    end
    if (plan_busy > 0) plan_busy--;
  endtask

  // One command word, then ticks until the block is free again; some of those
  // ticks carry commands that must be ignored while busy.
  task automatic issue_command(logic [1:0] req, logic [7:0] idx, logic [15:0] val,
                               sdo_mode_t sm, int idle_ticks);
    logic [1:0] noise;
    push_tick(req, idx, val, sdo_bit(sm));
    while (plan_busy > 0) begin
      noise = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : REQ_NONE;
      push_tick(noise, 8'($urandom), 16'($urandom), sdo_bit(sm));
    end
    repeat (idle_ticks) push_tick(REQ_NONE, 8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic random_command();
    int pick;
    int cap;
    logic [1:0] req;
    logic [7:0] idx;
    logic [15:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 40) req = REQ_WRITE;
    else if (pick < 82) req = REQ_READ;
    else req = REQ_SLEEP;
    idx = ($urandom_range(0, 9) == 0) ? DATA_ONLY_INDEX : 8'($urandom);
    val = 16'($urandom);
    if (req == REQ_SLEEP) begin
      // Keep sleeps short so the run stays within its budget.
      cap = 60 / int'(plan_tpm);
      if (cap > 0) val = 16'($urandom_range(0, cap));
      else val = 16'd0;
    end
    issue_command(req, idx, val, SDO_RAND,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
  endtask

  task automatic drain_and_settle();
    while (tick_q.size() != 0 || in_valid || pin_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ticks_per_ms(logic [15:0] rate);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= rate;
    @(negedge clk);
    cfg_we <= 1'b0;
    pm_tpm = rate;
    plan_tpm = rate;
  endtask

  // Input side: offer pending words at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || word_taken) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          next_word = tick_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_word.req_type;
          in_reg_index <= next_word.reg_index;
          in_value <= next_word.value;
          in_sdo <= next_word.sdo;
          send_wait = gaps_on ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, with one long hold-off to fill the block up.
  always @(negedge clk) begin
    if (!squeezed && results_seen >= 40 && tick_q.size() > 100) begin
      squeezed = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (gaps_on) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        pin_expect.push_back(panel_tick({in_req_type, in_reg_index, in_value, in_sdo}));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pin_expect.size() == 0) begin
          $error("result word arrived with nothing expected");
          err_count++;
        end else begin
          want = pin_expect.pop_front();
          field_check("chip_select", 16'(want.chip_select), 16'(out_chip_select));
          field_check("serial_clock", 16'(want.serial_clock), 16'(out_serial_clock));
          field_check("serial_data", 16'(want.serial_data), 16'(out_serial_data));
          field_check("busy_res", 16'(want.busy_res), 16'(out_busy_res));
          field_check("accepted", 16'(want.accepted), 16'(out_accepted));
          field_check("read_data", want.read_data, out_read_data);
          field_check("read_valid", 16'(want.read_valid), 16'(out_read_valid));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset rate.
    issue_command(REQ_WRITE, 8'h81, 16'h5AC3, SDO_RAND, 1);
    issue_command(REQ_WRITE, DATA_ONLY_INDEX, 16'hA5A5, SDO_RAND, 0);
    issue_command(REQ_READ, DATA_ONLY_INDEX, 16'hFFFF, SDO_HIGH, 3);
    issue_command(REQ_SLEEP, 8'h11, 16'h0000, SDO_RAND, 0);
    drain_and_settle();

    // Slowest rate; this phase runs with no idling on either side.
    set_ticks_per_ms(16'd1);
    gaps_on = 1'b0;
    issue_command(REQ_SLEEP, 8'h3C, 16'h0003, SDO_RAND, 0);
    random_command();
    drain_and_settle();

    set_ticks_per_ms(16'hFFFF);
    gaps_on = 1'b1;
    issue_command(REQ_SLEEP, 8'h00, 16'h0000, SDO_RAND, 1);
    random_command();
    drain_and_settle();

    set_ticks_per_ms(16'($urandom_range(2, 40)));
    random_command();
    drain_and_settle();

    set_ticks_per_ms(16'($urandom_range(41, 65535)));
    random_command();
    drain_and_settle();

    set_ticks_per_ms(TICKS_PER_MS_RST);
    random_command();
    drain_and_settle();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
